@@ hdl/sfr_pkg.sv @@
`default_nettype none
package sfr_pkg;

	localparam int FRAME_LENGTH_DEF = 39;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
	localparam logic [7:0] HEADER_SECOND_RST = 8'd85;

	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_FIRST  = 1'b0,
		REG_HEADER_SECOND = 1'b1
	} cfg_reg_t;

	localparam int NUM_STEPS = 35;
	localparam int UPC_W     = 6;
	localparam int FID_W     = 5;

	// Reciprocal for an exact floor(x / 100) over all 16-bit x.
	localparam logic [16:0] DIV100_MUL   = 17'd83887;
	localparam int          DIV100_SHIFT = 23;

	typedef enum logic [1:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		FMT_RAW,
		FMT_SEXT16,
		FMT_DIV100
	} fmt_t;

	typedef struct packed {
		logic [UPC_W-1:0] addr;
		logic             first;
		logic             emit;
		fmt_t             fmt;
		logic [FID_W-1:0] fid;
		logic             fin;
	} ucw_t;

	typedef struct packed {
		logic start;
		logic error;
	} seq_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} seq_stat_t;

	function automatic ucw_t mk_ucw(input logic [UPC_W-1:0] a, input logic f, input logic e,
			input fmt_t m, input logic [FID_W-1:0] id, input logic fin);
		ucw_t w;
		w.addr  = a;
		w.first = f;
		w.emit  = e;
		w.fmt   = m;
		w.fid   = id;
		w.fin   = fin;
		return w;
	endfunction

	// Decode program: one store byte per step, shifted into the accumulator.
	// A step marked first starts a new field; a step marked emit hands it out.
	function automatic ucw_t ucode(input logic [UPC_W-1:0] step);
		ucw_t w;
		case (step) inside
			6'd0:              w = mk_ucw(step, 1'b1, 1'b0, FMT_RAW, 5'd0, 1'b0);
			6'd1, 6'd2:        w = mk_ucw(step, 1'b0, 1'b0, FMT_RAW, 5'd0, 1'b0);
			6'd3:              w = mk_ucw(step, 1'b0, 1'b1, FMT_RAW, 5'd0, 1'b0);
			6'd4:              w = mk_ucw(step, 1'b1, 1'b0, FMT_RAW, 5'd1, 1'b0);
			6'd5, 6'd6:        w = mk_ucw(step, 1'b0, 1'b0, FMT_RAW, 5'd1, 1'b0);
			6'd7:              w = mk_ucw(step, 1'b0, 1'b1, FMT_RAW, 5'd1, 1'b0);
			6'd8:              w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd2, 1'b0);
			6'd9:              w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd3, 1'b0);
			6'd10:             w = mk_ucw(step, 1'b1, 1'b0, FMT_RAW, 5'd4, 1'b0);
			6'd11:             w = mk_ucw(step, 1'b0, 1'b1, FMT_RAW, 5'd4, 1'b0);
			6'd12:             w = mk_ucw(step, 1'b1, 1'b0, FMT_RAW, 5'd5, 1'b0);
			6'd13:             w = mk_ucw(step, 1'b0, 1'b1, FMT_RAW, 5'd5, 1'b0);
			6'd14:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd6, 1'b0);
			6'd15:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd7, 1'b0);
			6'd16:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd8, 1'b0);
			6'd17:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd9, 1'b0);
			6'd18:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd10, 1'b0);
			6'd19:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd11, 1'b0);
			6'd20:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd12, 1'b0);
			6'd21:             w = mk_ucw(step, 1'b1, 1'b0, FMT_RAW, 5'd13, 1'b0);
			6'd22:             w = mk_ucw(step, 1'b0, 1'b1, FMT_RAW, 5'd13, 1'b0);
			6'd23:             w = mk_ucw(step, 1'b1, 1'b0, FMT_SEXT16, 5'd14, 1'b0);
			6'd24:             w = mk_ucw(step, 1'b0, 1'b1, FMT_SEXT16, 5'd14, 1'b0);
			6'd25:             w = mk_ucw(step, 1'b1, 1'b0, FMT_DIV100, 5'd15, 1'b0);
			6'd26:             w = mk_ucw(step, 1'b0, 1'b1, FMT_DIV100, 5'd15, 1'b0);
			6'd27:             w = mk_ucw(step, 1'b1, 1'b0, FMT_DIV100, 5'd16, 1'b0);
			6'd28:             w = mk_ucw(step, 1'b0, 1'b1, FMT_DIV100, 5'd16, 1'b0);
			6'd29:             w = mk_ucw(step, 1'b1, 1'b0, FMT_DIV100, 5'd17, 1'b0);
			6'd30:             w = mk_ucw(step, 1'b0, 1'b1, FMT_DIV100, 5'd17, 1'b0);
			6'd31:             w = mk_ucw(step, 1'b1, 1'b0, FMT_DIV100, 5'd18, 1'b0);
			6'd32:             w = mk_ucw(step, 1'b0, 1'b1, FMT_DIV100, 5'd18, 1'b0);
			6'd33:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd19, 1'b0);
			6'd34:             w = mk_ucw(step, 1'b1, 1'b1, FMT_RAW, 5'd20, 1'b1);
			default:           w = mk_ucw(step, 1'b1, 1'b0, FMT_RAW, 5'd0, 1'b1);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ hdl/sfr_if.sv @@
`default_nettype none
interface sfr_rx_if ();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_fld_if import sfr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [FID_W-1:0]   field_id;
	logic signed [31:0] value;
	logic               last;

	modport source (output valid, output kind, output field_id, output value, output last,
		input ready);
	modport sink (input valid, input kind, input field_id, input value, input last,
		output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/sensor_frame_receiver_top.sv @@
// Sensor frame receiver.
// Bytes arrive on rx, one per transfer. The block hunts for the two header
// bytes (set through cfg, index 0 and 1) and the length byte, then stores the
// payload and the checksum byte. Any mismatch in the sync sequence returns it
// to hunting without output.
// After the checksum byte of a good frame, a microcoded sequencer reads the
// frame store one byte per cycle while the output does not stall (35 steps)
// and hands 21 fields out on the fields channel. The start command sets the
// run flag; each step reads its byte into stage one, and a step that emits
// loads its field into the output register. rx is not ready while that
// run is in progress. A bad checksum raises valid for a single error item
// at the edge that takes the last byte.
// If the receiver stalls, the output register holds its item and the
// sequencer waits; the final byte of a frame is refused while an earlier item
// still sits unclaimed in the output register.
// Reset returns the parser to hunting, clears the sum and restores the header
// registers. The frame store is not cleared; every entry is written before it is read.
// cfg is always ready and must be written only while the block is idle; the block does not enforce this.
`default_nettype none
module sensor_frame_receiver_top import sfr_pkg::*; #(
	parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sfr_rx_if.sink    rx,
	sfr_fld_if.source fields,
	sfr_cfg_if.sink   cfg
);

	localparam int STORE_DEPTH = FRAME_LENGTH - 3;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CW          = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(STORE_DEPTH - 1);
	localparam logic [7:0]    LEN_BYTE = 8'(FRAME_LENGTH - 1);

	phase_t      phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  hdr_first_q;
	logic [7:0]  hdr_second_q;
	logic        rx_xfer;
	logic        last_byte;
	logic        wr_en;
	seq_cmd_t    cmd;
	seq_stat_t   stat;

	assign last_byte = (cnt_q == LAST_IDX);
	assign rx.ready  = !stat.busy && !(phase_q == PH_DATA && last_byte && stat.out_full);
	assign rx_xfer   = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= HEADER_FIRST_RST;
			hdr_second_q <= HEADER_SECOND_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_HEADER_FIRST:  hdr_first_q  <= cfg.data;
				REG_HEADER_SECOND: hdr_second_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		wr_en   = 1'b0;
		cmd     = '0;
		if (rx_xfer) begin
			unique case (phase_q)
				PH_HUNT1: begin
					cnt_d = '0;
					if (rx.rx_byte == hdr_first_q) begin
						phase_d = PH_HUNT2;
						sum_d   = rx.rx_byte;
					end
				end
				PH_HUNT2: begin
					cnt_d = '0;
					if (rx.rx_byte == hdr_second_q) begin
						phase_d = PH_LEN;
						sum_d   = sum_q + rx.rx_byte;
					end else begin
						phase_d = PH_HUNT1;
					end
				end
				PH_LEN: begin
					cnt_d = '0;
					if (rx.rx_byte == LEN_BYTE) begin
						phase_d = PH_DATA;
						sum_d   = sum_q + rx.rx_byte;
					end else begin
						phase_d = PH_HUNT1;
					end
				end
				PH_DATA: begin
					wr_en = 1'b1;
					if (last_byte) begin
						// The last stored byte is the checksum and is not summed.
						phase_d = PH_HUNT1;
						cnt_d   = '0;
						if (sum_q == rx.rx_byte) begin
							cmd.start = 1'b1;
						end else begin
							cmd.error = 1'b1;
						end
					end else begin
						cnt_d = cnt_q + 1'b1;
						sum_d = sum_q + rx.rx_byte;
					end
				end
				default: phase_d = PH_HUNT1;
			endcase
		end
	end

	sfr_seq #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (rx.rx_byte),
		.cmd     (cmd),
		.stat    (stat),
		.fields  (fields)
	);

endmodule
`default_nettype wire

@@ hdl/sfr_ram.sv @@
`default_nettype none
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

@@ hdl/sfr_seq.sv @@
`default_nettype none
module sfr_seq import sfr_pkg::*; #(
	parameter int STORE_DEPTH = FRAME_LENGTH_DEF - 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
	input  wire logic [7:0]                     wr_data,
	input  wire seq_cmd_t                       cmd,
	output seq_stat_t                           stat,
	sfr_fld_if.source                           fields
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic             run_q;
	logic [UPC_W-1:0] pc_q;
	logic             pend_s1;
	ucw_t             ctl_s1;
	ucw_t             ucw;
	logic [31:0]      acc_q;
	logic [31:0]      new_acc;
	logic [32:0]      prod;
	logic [31:0]      value_d;
	logic [7:0]       rd_data;
	logic             out_free;
	logic             proc;
	logic             issue;

	logic               out_valid_q;
	logic               kind_q;
	logic [FID_W-1:0]   fid_q;
	logic signed [31:0] value_q;
	logic               last_q;

	assign ucw      = ucode(pc_q);
	assign out_free = !out_valid_q || fields.ready;
	// A step that emits waits in stage one until the output register can take its field.
	assign proc     = pend_s1 && (!ctl_s1.emit || out_free);
	assign issue    = run_q && (!pend_s1 || proc);

	sfr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (AW'(ucw.addr)),
		.rd_data (rd_data)
	);

	always_comb begin
		new_acc = ctl_s1.first ? {24'b0, rd_data} : {acc_q[23:0], rd_data};
		prod    = 33'(new_acc[15:0]) * 33'(DIV100_MUL);
		case (ctl_s1.fmt)
			FMT_SEXT16: value_d = {{16{new_acc[15]}}, new_acc[15:0]};
			FMT_DIV100: value_d = 32'(prod >> DIV100_SHIFT);
			default:    value_d = new_acc;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			pc_q    <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.start) begin
				run_q <= 1'b1;
				pc_q  <= '0;
			end else if (issue) begin
				if (ucw.fin) begin
					run_q <= 1'b0;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (proc) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ctl_s1 <= ucw;
		end
		if (proc) begin
			acc_q <= new_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.error || (proc && ctl_s1.emit)) begin
			out_valid_q <= 1'b1;
		end else if (fields.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.error) begin
			kind_q  <= 1'b1;
			fid_q   <= '0;
			value_q <= '0;
			last_q  <= 1'b1;
		end else if (proc && ctl_s1.emit) begin
			kind_q  <= 1'b0;
			fid_q   <= ctl_s1.fid;
			value_q <= value_d;
			last_q  <= ctl_s1.fin;
		end
	end

	assign fields.valid    = out_valid_q;
	assign fields.kind     = kind_q;
	assign fields.field_id = fid_q;
	assign fields.value    = value_q;
	assign fields.last     = last_q;

	assign stat.busy     = run_q || pend_s1;
	assign stat.out_full = out_valid_q && !fields.ready;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !run_q && !pend_s1)
		else $error("decode started while a run is in progress");

	a_error_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.error |-> !run_q && !pend_s1 && out_free)
		else $error("error item raised while the output register is taken");

	a_fin_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && ctl_s1.fin) |-> !run_q)
		else $error("sequencer still running after its final step");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> pc_q < UPC_W'(NUM_STEPS))
		else $error("step counter ran past the program");

endmodule
`default_nettype wire
